### hdl/dadsr_pkg.sv
// Package: shared constants, codes and types of the dual envelope generator and VCA.
`default_nettype none
package dadsr_pkg;

  localparam int SAMPLE_WIDTH_DEF    = 16;
  localparam int LEVEL_FRAC_BITS_DEF = 23;
  localparam int QUEUE_DEPTH         = 2;

  localparam int CFG_WIDTH   = 48;
  localparam int CFG_IDX_W   = 3;
  localparam int STEP_WIDTH  = 24;
  localparam int GAIN_WIDTH  = 16;
  localparam int GAIN_FRAC   = 15;
  localparam int THR_WIDTH   = 16;

  localparam logic [GAIN_WIDTH-1:0] GAIN_UNITY = 16'h8000;

  localparam logic [CFG_WIDTH-1:0]  RST_L_AD   = 48'd5402264558;
  localparam logic [CFG_WIDTH-1:0]  RST_L_RS   = 48'd70368744177986;
  localparam logic [CFG_WIDTH-1:0]  RST_R_AD   = 48'd5402263874;
  localparam logic [CFG_WIDTH-1:0]  RST_R_RS   = 48'd70368744177986;
  localparam logic [GAIN_WIDTH-1:0] RST_GAIN   = 16'd32768;
  localparam logic [THR_WIDTH-1:0]  RST_THR    = 16'd6554;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_L_AD   = 3'd0,
    CFG_L_RS   = 3'd1,
    CFG_R_AD   = 3'd2,
    CFG_R_RS   = 3'd3,
    CFG_L_GAIN = 3'd4,
    CFG_R_GAIN = 3'd5,
    CFG_THR    = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    EVT_NONE    = 2'd0,
    EVT_ATTACK  = 2'd1,
    EVT_RELEASE = 2'd2
  } gate_evt_e;

  typedef enum logic [2:0] {
    PH_OFF     = 3'd0,
    PH_ATTACK  = 3'd1,
    PH_DECAY   = 3'd2,
    PH_SUSTAIN = 3'd3,
    PH_RELEASE = 3'd4
  } phase_e;

  typedef struct packed {
    logic [STEP_WIDTH-1:0] attack;
    logic [STEP_WIDTH-1:0] decay;
    logic [STEP_WIDTH-1:0] release_step;
    logic [STEP_WIDTH-1:0] sustain;
    logic [GAIN_WIDTH-1:0] gain;
  } chan_cfg_t;

endpackage
`default_nettype wire

### hdl/dadsr_queue.sv
// Short register queue between the gate classifier and the envelope pipeline.
`default_nettype none
module dadsr_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] push_data_i,
  output logic                  ready_o,
  output logic                  valid_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      pop_data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign ready_o    = (cnt_q != FULL);
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && ready_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

### hdl/dadsr_front.sv
// Front end: input selection, gate thresholding and edge classification.
`default_nettype none
module dadsr_front
  import dadsr_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic signed [SAMPLE_WIDTH-1:0] left_audio_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] right_audio_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] left_gate_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] right_gate_i,
  input  wire logic                           right_gate_present_i,
  input  wire logic                           right_audio_present_i,
  input  wire logic signed [THR_WIDTH-1:0]    threshold_i,
  input  wire logic                           q_ready_i,
  output logic                                q_push_o,
  output logic [2*SAMPLE_WIDTH+3:0]           q_data_o
);

  localparam int GW = (SAMPLE_WIDTH > THR_WIDTH) ? SAMPLE_WIDTH : THR_WIDTH;

  logic signed [GW-1:0]           thr_ext, gate_l_ext, gate_r_ext;
  logic signed [SAMPLE_WIDTH-1:0] gate_r_sel, audio_r_sel;
  logic                           high_l, high_r, accept;
  logic                           was_high_l_q, was_high_r_q;
  gate_evt_e                      evt_l, evt_r;

  assign in_stall_o  = !q_ready_i;
  assign accept      = in_valid_i && q_ready_i;
  assign q_push_o    = accept;

  assign gate_r_sel  = right_gate_present_i ? right_gate_i : left_gate_i;
  assign audio_r_sel = right_audio_present_i ? right_audio_i : left_audio_i;

  assign thr_ext    = GW'(threshold_i);
  assign gate_l_ext = GW'(left_gate_i);
  assign gate_r_ext = GW'(gate_r_sel);
  assign high_l     = gate_l_ext > thr_ext;
  assign high_r     = gate_r_ext > thr_ext;

  always_comb begin
    evt_l = EVT_NONE;
    evt_r = EVT_NONE;
    if (high_l && !was_high_l_q) begin
      evt_l = EVT_ATTACK;
    end else if (!high_l && was_high_l_q) begin
      evt_l = EVT_RELEASE;
    end
    if (high_r && !was_high_r_q) begin
      evt_r = EVT_ATTACK;
    end else if (!high_r && was_high_r_q) begin
      evt_r = EVT_RELEASE;
    end
  end

  assign q_data_o = {audio_r_sel, left_audio_i, evt_r, evt_l};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      was_high_l_q <= 1'b0;
      was_high_r_q <= 1'b0;
    end else if (accept) begin
      was_high_l_q <= high_l;
      was_high_r_q <= high_r;
    end
  end

endmodule
`default_nettype wire

### hdl/dadsr_back.sv
// Back end: envelope update, gain scaling and audio multiply, with output register.
`default_nettype none
module dadsr_back
  import dadsr_pkg::*;
#(
  parameter int SAMPLE_WIDTH        = SAMPLE_WIDTH_DEF,
  parameter int LEVEL_FRACTION_BITS = LEVEL_FRAC_BITS_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire chan_cfg_t [1:0]                       cfg_i,
  input  wire logic                                  q_valid_i,
  input  wire logic [2*SAMPLE_WIDTH+3:0]             q_data_i,
  output logic                                       q_pop_o,
  output logic                                       out_valid_o,
  input  wire logic                                  out_stall_i,
  output logic [1:0][SAMPLE_WIDTH-1:0]               audio_out_o,
  output logic [1:0][LEVEL_FRACTION_BITS:0]          env_out_o
);

  localparam int SW  = SAMPLE_WIDTH;
  localparam int LFB = LEVEL_FRACTION_BITS;
  localparam int LW  = LFB + 1;
  localparam int CW  = ((LW > STEP_WIDTH) ? LW : STEP_WIDTH) + 2;
  localparam int GPW = LW + GAIN_WIDTH;
  localparam int PW  = SW + LW + 1;

  localparam logic signed [CW-1:0] ONE = {{(CW-LW){1'b0}}, 1'b1, {LFB{1'b0}}};
  localparam logic signed [CW-1:0] ZERO = '0;
  localparam logic [GPW-1:0] GAIN_RND = GPW'(1) << (GAIN_FRAC - 1);
  localparam logic signed [PW-1:0] AUD_RND = {{(PW-LFB){1'b0}}, 1'b1, {(LFB-1){1'b0}}};
  localparam logic signed [PW-1:0] SMAX = {{(PW-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [PW-1:0] SMIN = ~SMAX;

  logic en, va_q, vb_q, vc_q;

  assign en          = !vc_q || !out_stall_i;
  assign q_pop_o     = en && q_valid_i;
  assign out_valid_o = vc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (en) begin
      va_q <= q_valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  for (genvar c = 0; c < 2; c++) begin : g_chan
    gate_evt_e              evt;
    phase_e                 phase_q, phase_d, phase_cur;
    logic [LW-1:0]          level_q, level_d;
    logic signed [CW-1:0]   lvl, att, dec, rel, sus_raw, sus, sum, diff_d, diff_r;
    logic [GAIN_WIDTH-1:0]  gain;
    logic [GPW-1:0]         gprod;
    logic signed [SW-1:0]   aud_in, a_aud_q, b_aud_q;
    logic [LW-1:0]          b_env_q;
    logic signed [LW:0]     env_s;
    logic signed [PW-1:0]   aprod, ashift, asat;
    logic [SW-1:0]          c_aud_q;
    logic [LW-1:0]          c_env_q;

    assign evt    = gate_evt_e'(q_data_i[2*c +: 2]);
    assign aud_in = q_data_i[4 + c*SW +: SW];

    assign lvl     = CW'(level_q);
    assign att     = CW'(cfg_i[c].attack);
    assign dec     = CW'(cfg_i[c].decay);
    assign rel     = CW'(cfg_i[c].release_step);
    assign sus_raw = CW'(cfg_i[c].sustain);
    assign sus     = (sus_raw > ONE) ? ONE : sus_raw;
    assign sum     = lvl + att;
    assign diff_d  = lvl - dec;
    assign diff_r  = lvl - rel;

    always_comb begin
      if (evt == EVT_ATTACK) begin
        phase_cur = PH_ATTACK;
      end else if (evt == EVT_RELEASE) begin
        phase_cur = PH_RELEASE;
      end else begin
        phase_cur = phase_q;
      end
    end

    always_comb begin
      phase_d = phase_cur;
      level_d = level_q;
      unique case (phase_cur)
        PH_ATTACK: begin
          if (sum >= ONE) begin
            level_d = LW'(ONE);
            phase_d = PH_DECAY;
          end else begin
            level_d = LW'(sum);
          end
        end
        PH_DECAY: begin
          if (diff_d <= sus) begin
            level_d = LW'(sus);
            phase_d = PH_SUSTAIN;
          end else begin
            level_d = LW'(diff_d);
          end
        end
        PH_RELEASE: begin
          if (diff_r <= ZERO) begin
            level_d = '0;
            phase_d = PH_OFF;
          end else begin
            level_d = LW'(diff_r);
          end
        end
        default: begin
          level_d = level_q;
        end
      endcase
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        phase_q <= PH_OFF;
        level_q <= '0;
      end else if (q_pop_o) begin
        phase_q <= phase_d;
        level_q <= level_d;
      end
    end

    assign gain  = (cfg_i[c].gain > GAIN_UNITY) ? GAIN_UNITY : cfg_i[c].gain;
    assign gprod = level_q * gain + GAIN_RND;

    assign env_s  = {1'b0, b_env_q};
    assign aprod  = b_aud_q * env_s + AUD_RND;
    assign ashift = aprod >>> LFB;

    always_comb begin
      if (ashift > SMAX) begin
        asat = SMAX;
      end else if (ashift < SMIN) begin
        asat = SMIN;
      end else begin
        asat = ashift;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        a_aud_q <= aud_in;
        b_aud_q <= a_aud_q;
        b_env_q <= gprod[GAIN_FRAC +: LW];
        c_aud_q <= asat[SW-1:0];
        c_env_q <= b_env_q;
      end
    end

    assign audio_out_o[c] = c_aud_q;
    assign env_out_o[c]   = c_env_q;
  end

endmodule
`default_nettype wire

### hdl/dual_adsr_envelope_vca.sv
// Dual envelope generator with VCA: top level with configuration registers.
//
// Input channel: in_valid_i / in_stall_o carry one stereo beat (two audio and
// two gate samples plus right-input presence flags). Output channel:
// out_valid_o / out_stall_i carry the two VCA samples and the two envelopes.
// Configuration: cfg_we_i writes register cfg_idx_i with cfg_data_i; write
// only while no beat is in flight. Index 7 is ignored.
// Throughput: one beat per cycle while the output is not stalled. A front
// stage classifies gate edges into a two-entry queue; the back pipeline
// updates each envelope with a combinational add and compare, then scales
// by gain and multiplies the audio. An accepted beat passes the queue, the
// level register, the scaled-envelope register and the output register.
// Reset: envelopes off at level zero, gate history low, registers at their
// defaults, queue and pipeline empty.
// A stalled output freezes the whole back pipeline; the queue then fills and
// in_stall_o rises until the receiver takes the held beat.
`default_nettype none
module dual_adsr_envelope_vca
  import dadsr_pkg::*;
#(
  parameter int SAMPLE_WIDTH        = SAMPLE_WIDTH_DEF,
  parameter int LEVEL_FRACTION_BITS = LEVEL_FRAC_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]                cfg_idx_i,
  input  wire logic [CFG_WIDTH-1:0]                cfg_data_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic signed [SAMPLE_WIDTH-1:0]      left_audio_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0]      right_audio_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0]      left_gate_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0]      right_gate_i,
  input  wire logic                                right_gate_present_i,
  input  wire logic                                right_audio_present_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic signed [SAMPLE_WIDTH-1:0]           left_audio_out_o,
  output logic signed [SAMPLE_WIDTH-1:0]           right_audio_out_o,
  output logic [LEVEL_FRACTION_BITS:0]             left_envelope_out_o,
  output logic [LEVEL_FRACTION_BITS:0]             right_envelope_out_o
);

  localparam int QW = 2 * SAMPLE_WIDTH + 4;

  logic [CFG_WIDTH-1:0]  l_ad_q, l_rs_q, r_ad_q, r_rs_q;
  logic [GAIN_WIDTH-1:0] l_gain_q, r_gain_q;
  logic [THR_WIDTH-1:0]  thr_q;

  chan_cfg_t [1:0]                      chan_cfg;
  logic                                 q_push, q_ready, q_valid, q_pop;
  logic [QW-1:0]                        q_wdata, q_rdata;
  logic [1:0][SAMPLE_WIDTH-1:0]         audio_out;
  logic [1:0][LEVEL_FRACTION_BITS:0]    env_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l_ad_q   <= RST_L_AD;
      l_rs_q   <= RST_L_RS;
      r_ad_q   <= RST_R_AD;
      r_rs_q   <= RST_R_RS;
      l_gain_q <= RST_GAIN;
      r_gain_q <= RST_GAIN;
      thr_q    <= RST_THR;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_L_AD:   l_ad_q   <= cfg_data_i;
        CFG_L_RS:   l_rs_q   <= cfg_data_i;
        CFG_R_AD:   r_ad_q   <= cfg_data_i;
        CFG_R_RS:   r_rs_q   <= cfg_data_i;
        CFG_L_GAIN: l_gain_q <= cfg_data_i[GAIN_WIDTH-1:0];
        CFG_R_GAIN: r_gain_q <= cfg_data_i[GAIN_WIDTH-1:0];
        CFG_THR:    thr_q    <= cfg_data_i[THR_WIDTH-1:0];
        default: begin
          l_ad_q <= l_ad_q;
        end
      endcase
    end
  end

  assign chan_cfg[0] = '{attack:       l_ad_q[STEP_WIDTH-1:0],
                         decay:        l_ad_q[CFG_WIDTH-1:STEP_WIDTH],
                         release_step: l_rs_q[STEP_WIDTH-1:0],
                         sustain:      l_rs_q[CFG_WIDTH-1:STEP_WIDTH],
                         gain:         l_gain_q};
  assign chan_cfg[1] = '{attack:       r_ad_q[STEP_WIDTH-1:0],
                         decay:        r_ad_q[CFG_WIDTH-1:STEP_WIDTH],
                         release_step: r_rs_q[STEP_WIDTH-1:0],
                         sustain:      r_rs_q[CFG_WIDTH-1:STEP_WIDTH],
                         gain:         r_gain_q};

  dadsr_front #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .left_audio_i,
    .right_audio_i,
    .left_gate_i,
    .right_gate_i,
    .right_gate_present_i,
    .right_audio_present_i,
    .threshold_i (thr_q),
    .q_ready_i   (q_ready),
    .q_push_o    (q_push),
    .q_data_o    (q_wdata)
  );

  dadsr_queue #(
    .WIDTH(QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i,
    .rst_ni,
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .ready_o     (q_ready),
    .valid_o     (q_valid),
    .pop_i       (q_pop),
    .pop_data_o  (q_rdata)
  );

  dadsr_back #(
    .SAMPLE_WIDTH       (SAMPLE_WIDTH),
    .LEVEL_FRACTION_BITS(LEVEL_FRACTION_BITS)
  ) u_back (
    .clk_i,
    .rst_ni,
    .cfg_i       (chan_cfg),
    .q_valid_i   (q_valid),
    .q_data_i    (q_rdata),
    .q_pop_o     (q_pop),
    .out_valid_o,
    .out_stall_i,
    .audio_out_o (audio_out),
    .env_out_o   (env_out)
  );

  assign left_audio_out_o     = audio_out[0];
  assign right_audio_out_o    = audio_out[1];
  assign left_envelope_out_o  = env_out[0];
  assign right_envelope_out_o = env_out[1];

endmodule
`default_nettype wire
